### rtl/lef_pkg.sv
// shared types, constants and register codes of the laplacian edge filter
`default_nettype none

package lef_pkg;

  // fixed field widths
  localparam int unsigned PixelBits   = 8;
  localparam int unsigned CfgW        = 11;
  localparam int unsigned GainW       = 8;
  localparam int unsigned EdgeW       = 15;
  localparam int unsigned CfgIdxW     = 2;

  // default line store depth
  localparam int unsigned LefMaxWidth = 1024;

  // depth of the request queue between front and back
  localparam int unsigned LefQueueDepth = 2;

  // laplacian spans -4*max..4*max, three bits above the pixel
  localparam int unsigned LapW  = PixelBits + 3;
  localparam int unsigned ProdW = LapW + GainW + 1;

  localparam int EdgeMax = 16383;
  localparam int EdgeMin = -16384;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain        = 2'd2;

  localparam logic [CfgW-1:0]  ResetWidth  = 11'd640;
  localparam logic [CfgW-1:0]  ResetHeight = 11'd480;
  localparam logic [GainW-1:0] ResetGain   = 8'd24;

  // request kinds
  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [PixelBits-1:0] pixel;
  } lef_in_t;

  typedef struct packed {
    logic signed [EdgeW-1:0] edge_value;
    logic                    end_of_row;
    logic                    end_of_frame;
  } lef_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                 store;
    logic                 first_row;
    logic                 draining;
    logic                 last_col;
    logic [PixelBits-1:0] pix;
  } lef_cmd_t;

endpackage

`default_nettype wire

### rtl/lef_front.sv
// front end: frame counters and classification of each request
`default_nettype none

module lef_front import lef_pkg::*; #(
  parameter int unsigned MAX_WIDTH = LefMaxWidth,
  localparam int unsigned ColW = $clog2(MAX_WIDTH),
  localparam int unsigned EffW = ColW + 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_i,
  input  wire lef_in_t         in_data_i,
  input  wire logic [CfgW-1:0] width_i,
  input  wire logic [CfgW-1:0] height_i,
  output logic                 push_o,
  output lef_cmd_t             cmd_o,
  output logic [ColW-1:0]      col_o
);

  logic [ColW-1:0] col_q, col_d, col_n;
  logic [CfgW-1:0] row_q, row_d, row_n;
  logic [EffW-1:0] eff_w;
  logic [CfgW-1:0] eff_h;
  logic            draining, take, last_col, store;

  always_comb begin
    if (width_i == '0) begin
      eff_w = EffW'(1);
    end else if (32'(width_i) > 32'(MAX_WIDTH)) begin
      eff_w = EffW'(MAX_WIDTH);
    end else begin
      eff_w = EffW'(width_i);
    end
    eff_h = (height_i == '0) ? CfgW'(1) : height_i;
  end

  always_comb begin
    col_n = ({1'b0, col_q} >= eff_w) ? '0 : col_q;
    row_n = row_q;
    // a row count past the height restarts the frame
    if (row_q > eff_h) begin
      row_n = '0;
      col_n = '0;
    end
    draining = (row_n == eff_h);
    take     = ((in_data_i.op == OpDrain) == draining);
    last_col = (({1'b0, col_n} + EffW'(1)) == eff_w);
    store    = (row_n == '0);

    col_d = col_n;
    row_d = row_n;
    if (take) begin
      if (last_col) begin
        col_d = '0;
        if (store) begin
          row_d = CfgW'(1);
        end else if (draining) begin
          row_d = '0;
        end else begin
          row_d = row_n + CfgW'(1);
        end
      end else begin
        col_d = col_n + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (req_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o          = req_i && take;
  assign cmd_o.store     = store;
  assign cmd_o.first_row = (row_n == CfgW'(1));
  assign cmd_o.draining  = draining;
  assign cmd_o.last_col  = last_col;
  assign cmd_o.pix       = in_data_i.pixel;
  assign col_o           = col_n;

endmodule

`default_nettype wire

### rtl/lef_fifo.sv
// small request queue between front and back
`default_nettype none

module lef_fifo import lef_pkg::*; #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = LefQueueDepth,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [DataW-1:0]      data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lef_back.sv
// back end: line stores, laplacian, gain scaling and output register
`default_nettype none

module lef_back import lef_pkg::*; #(
  parameter int unsigned MAX_WIDTH = LefMaxWidth,
  localparam int unsigned ColW = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire lef_cmd_t         cmd_i,
  input  wire logic [ColW-1:0]  col_i,
  output logic                  cmd_pop_o,
  input  wire logic [GainW-1:0] gain_i,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lef_out_t              out_data_o
);

  localparam logic signed [ProdW-1:0] SatHi = ProdW'(EdgeMax);
  localparam logic signed [ProdW-1:0] SatLo = ProdW'(EdgeMin);

  logic [PixelBits-1:0] newer_mem [MAX_WIDTH];
  logic [PixelBits-1:0] older_mem [MAX_WIDTH];

  // clearing sweep after reset
  logic            clr_q;
  logic [ColW-1:0] clr_addr_q;

  // read stage
  logic                 b_valid_q;
  lef_cmd_t             b_cmd_q;
  logic [ColW-1:0]      b_col_q;
  logic [PixelBits-1:0] nc_q, nr_q, ou_q;
  logic                 fwd_nc_q, fwd_nr_q, fwd_ou_q;
  logic [PixelBits-1:0] fwd_n_q, fwd_o_q;
  logic [PixelBits-1:0] prev_c_q;

  // laplacian stage
  logic                   s_valid_q;
  logic signed [LapW-1:0] lap_q;
  logic                   s_eor_q, s_eof_q;

  // output register
  logic     o_valid_q;
  lef_out_t o_data_q;

  logic                 o_free, s_free, s_adv, b_retire, b_emit, b_free, pop;
  logic [ColW-1:0]      col_r;
  logic                 nw_en, ow_en;
  logic [ColW-1:0]      nw_addr, ow_addr;
  logic [PixelBits-1:0] nw_data, ow_data;
  logic [PixelBits-1:0] up, centre, down, right, left;
  logic [LapW-1:0]      lap_sum;
  logic signed [ProdW-1:0] prod, quot, sat;

  assign o_free   = !o_valid_q || out_ready_i;
  assign s_adv    = s_valid_q && o_free;
  assign s_free   = !s_valid_q || o_free;
  assign b_retire = b_valid_q && (b_cmd_q.store || s_free);
  assign b_emit   = b_retire && !b_cmd_q.store;
  assign b_free   = !b_valid_q || b_retire;
  assign pop      = cmd_valid_i && b_free && !clr_q;

  assign cmd_pop_o  = pop;
  assign clearing_o = clr_q;

  assign col_r = (col_i == ColW'(MAX_WIDTH - 1)) ? '0 : col_i + ColW'(1);

  // forwarded read data for the item in the read stage
  always_comb begin
    centre = fwd_nc_q ? fwd_n_q : nc_q;
    right  = b_cmd_q.last_col ? '0 : (fwd_nr_q ? fwd_n_q : nr_q);
    up     = b_cmd_q.first_row ? '0 : (fwd_ou_q ? fwd_o_q : ou_q);
    down   = b_cmd_q.draining ? '0 : b_cmd_q.pix;
    left   = (b_col_q == '0) ? '0 : prev_c_q;
    lap_sum = LapW'(left) + LapW'(right) + LapW'(up) + LapW'(down)
            - (LapW'(centre) << 2);
  end

  // line store writes: sweep after reset, else from the retiring item
  always_comb begin
    if (clr_q) begin
      nw_en   = 1'b1;
      ow_en   = 1'b1;
      nw_addr = clr_addr_q;
      ow_addr = clr_addr_q;
      nw_data = '0;
      ow_data = '0;
    end else begin
      nw_en   = b_retire && !b_cmd_q.draining;
      ow_en   = b_emit && !b_cmd_q.draining;
      nw_addr = b_col_q;
      ow_addr = b_col_q;
      nw_data = b_cmd_q.pix;
      ow_data = centre;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      newer_mem[nw_addr] <= nw_data;
    end
    if (ow_en) begin
      older_mem[ow_addr] <= ow_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      nc_q     <= newer_mem[col_i];
      nr_q     <= newer_mem[col_r];
      ou_q     <= older_mem[col_i];
      fwd_nc_q <= nw_en && (nw_addr == col_i);
      fwd_nr_q <= nw_en && (nw_addr == col_r);
      fwd_ou_q <= ow_en && (ow_addr == col_i);
      fwd_n_q  <= nw_data;
      fwd_o_q  <= ow_data;
      b_cmd_q  <= cmd_i;
      b_col_q  <= col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == ColW'(MAX_WIDTH - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      prev_c_q  <= '0;
    end else begin
      if (pop) begin
        b_valid_q <= 1'b1;
      end else if (b_retire) begin
        b_valid_q <= 1'b0;
      end
      if (b_emit) begin
        prev_c_q <= centre;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_emit) begin
      lap_q   <= $signed(lap_sum);
      s_eor_q <= b_cmd_q.last_col;
      s_eof_q <= b_cmd_q.last_col && b_cmd_q.draining;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (b_emit) begin
      s_valid_q <= 1'b1;
    end else if (s_adv) begin
      s_valid_q <= 1'b0;
    end
  end

  // gain scaling, divide by 16 toward zero, saturate
  always_comb begin
    prod = ProdW'(lap_q) * ProdW'($signed({1'b0, gain_i}));
    quot = (prod + (prod[ProdW-1] ? ProdW'(15) : ProdW'(0))) >>> 4;
    if (quot > SatHi) begin
      sat = SatHi;
    end else if (quot < SatLo) begin
      sat = SatLo;
    end else begin
      sat = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_adv) begin
      o_data_q.edge_value   <= EdgeW'(sat);
      o_data_q.end_of_row   <= s_eor_q;
      o_data_q.end_of_frame <= s_eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (s_adv) begin
      o_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

`default_nettype wire

### rtl/laplacian_edge_filter.sv
// top level of the streaming four-neighbour laplacian edge filter
`default_nettype none

// Grey pixels enter in raster order, one request per clock sustained while output
// is taken, and each produces at most one result: the four-neighbour laplacian
// of the pixel one row above, scaled by gain (unsigned Q4.4) and truncated toward
// zero, so output runs one row behind input. Drain requests (op = 1) after the
// last row push that row out; pixels are ignored while draining and drain
// requests at any other time. The front keeps the frame counters and classifies
// each request, a two-entry queue decouples it from the back, whose line stores
// take one write per store per cycle; a result passes the queue, read stage,
// laplacian stage and output register. After reset both line stores are zeroed
// over all MAX_WIDTH addresses, with in_ready_o low; configuration writes are
// taken at any time but must only be issued while no result is outstanding.
module laplacian_edge_filter import lef_pkg::*; #(
  parameter int unsigned MAX_WIDTH = LefMaxWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lef_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lef_out_t                out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned QueueW = $bits(lef_cmd_t) + ColW;

  logic [CfgW-1:0]  width_q, height_q;
  logic [GainW-1:0] gain_q;

  logic              req, push, fifo_full, fifo_empty, pop, clearing;
  lef_cmd_t          f_cmd, b_cmd;
  logic [ColW-1:0]   f_col, b_col;
  logic [QueueW-1:0] q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      gain_q   <= ResetGain;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        CfgGain:        gain_q   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !fifo_full && !clearing;
  assign req        = in_valid_i && in_ready_o;

  lef_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .in_data_i (in_data_i),
    .width_i   (width_q),
    .height_i  (height_q),
    .push_o    (push),
    .cmd_o     (f_cmd),
    .col_o     (f_col)
  );

  lef_fifo #(
    .DataW (QueueW),
    .Depth (LefQueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_col}),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .data_o  (q_out)
  );

  assign b_cmd = q_out[QueueW-1:ColW];
  assign b_col = q_out[ColW-1:0];

  lef_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!fifo_empty),
    .cmd_i       (b_cmd),
    .col_i       (b_col),
    .cmd_pop_o   (pop),
    .gain_i      (gain_q),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // no result can exist before the line stores are cleared
  a_no_out_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o)
    else $error("result shown during line store clearing");

  // the queue holds nothing when the clearing sweep ends
  a_queue_empty_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing) |-> fifo_empty)
    else $error("request queued during line store clearing");

  // end of frame only ever comes on the last pixel of a row
  a_eof_on_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.end_of_frame || out_data_o.end_of_row))
    else $error("end of frame without end of row");

endmodule

`default_nettype wire

### bench/lef_edge_checker.sv
// request watcher, scaled laplacian predictor and result comparison for the edge filter
module lef_edge_checker import lef_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire lef_in_t            in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire lef_out_t           out_data_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  logic [CfgW-1:0]      width_reg;
  logic [CfgW-1:0]      height_reg;
  logic [GainW-1:0]     gain_reg;
  logic [PixelBits-1:0] older_line [LefMaxWidth];
  logic [PixelBits-1:0] newer_line [LefMaxWidth];
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [PixelBits-1:0] prev_centre;
  lef_out_t             expected_edges_q [$];
  lef_out_t             oldest_edge;

  task automatic predict_edge(lef_in_t req);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    logic        draining;
    logic        last_col;
    int          up;
    int          centre;
    int          down;
    int          left_px;
    int          right_px;
    int          scaled;
    lef_out_t    res;
    w = (width_reg == 0) ? 1 : ((width_reg > LefMaxWidth) ? LefMaxWidth : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    // counters left beyond a shrunk geometry restart
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt > h) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    draining = (row_cnt == h);
    if ((req.op == OpDrain) != draining) return;
    x = col_cnt;
    last_col = (x + 1 == w);
    if (row_cnt == 0) begin
      // first row is only stored
      newer_line[x] = req.pixel;
      if (last_col) begin
        col_cnt = 0;
        row_cnt = 1;
      end else begin
        col_cnt = x + 1;
      end
      return;
    end
    up       = (row_cnt == 1) ? 0 : older_line[x];
    centre   = newer_line[x];
    down     = draining ? 0 : req.pixel;
    right_px = last_col ? 0 : newer_line[x + 1];
    left_px  = (x == 0) ? 0 : prev_centre;
    prev_centre = newer_line[x];
    if (!draining) begin
      older_line[x] = newer_line[x];
      newer_line[x] = req.pixel;
    end
    scaled = ((left_px + right_px + up + down - 4 * centre) * int'(gain_reg)) / 16;
    if (scaled > EdgeMax) scaled = EdgeMax;
    if (scaled < EdgeMin) scaled = EdgeMin;
    res.edge_value   = scaled[EdgeW-1:0];
    res.end_of_row   = last_col;
    res.end_of_frame = last_col && draining;
    expected_edges_q.push_back(res);
    if (last_col) begin
      col_cnt = 0;
      row_cnt = draining ? 0 : row_cnt + 1;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = ResetWidth;
      height_reg = ResetHeight;
      gain_reg   = ResetGain;
      for (int i = 0; i < LefMaxWidth; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      col_cnt      = 0;
      row_cnt      = 0;
      prev_centre  = '0;
      fail_count_o = 0;
      expected_edges_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageWidth:  width_reg = cfg_data_i;
          CfgImageHeight: height_reg = cfg_data_i;
          CfgGain:        gain_reg = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      // results leave only after passing the queue and the back's registers, so compare first
      if (out_valid_i && out_ready_i) begin
        if (expected_edges_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: edge %0d row_end %0b frame_end %0b",
                     $signed(out_data_i.edge_value), out_data_i.end_of_row,
                     out_data_i.end_of_frame);
        end else begin
          oldest_edge = expected_edges_q.pop_front();
          if (out_data_i.edge_value !== oldest_edge.edge_value ||
              out_data_i.end_of_row !== oldest_edge.end_of_row ||
              out_data_i.end_of_frame !== oldest_edge.end_of_frame) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: edge %0d/%0d row_end %0b/%0b frame_end %0b/%0b (exp/got)",
                       $signed(oldest_edge.edge_value), $signed(out_data_i.edge_value),
                       oldest_edge.end_of_row, out_data_i.end_of_row,
                       oldest_edge.end_of_frame, out_data_i.end_of_frame);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_edge(in_data_i);
    end
    pending_o = expected_edges_q.size();
  end

endmodule

### bench/laplacian_edge_filter_tb.sv
// clock, reset, request stimulus and verdict for the laplacian edge filter
module laplacian_edge_filter_tb;
  import lef_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  lef_in_t            in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  lef_out_t           out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  int   fail_count;
  int   pending;
  logic in_fire;
  int   send_idle;
  int   recv_idle;
  int   frame_items;

  laplacian_edge_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  lef_edge_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // request acceptance seen at the last rising edge
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #8000000;
    $display("[laplacian_edge_filter] ERROR");
    $finish;
  end

  task automatic send_request(logic op, logic [PixelBits-1:0] pix);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: op, pixel: pix};
    do @(negedge clk_i); while (!in_fire);
  endtask

  // all results in, then a hold-off for requests that give none
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic configure(logic [CfgW-1:0] w, logic [CfgW-1:0] h, logic [GainW-1:0] g);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgImageWidth;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= CfgImageHeight;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_idx_i  <= CfgGain;
    cfg_data_i <= CfgW'(g);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_frame(int unsigned w, int unsigned h, bit extremes, int noise,
                            int pause_at);
    for (int i = 0; i < w * h; i++) begin
      if (i == pause_at) wait_idle();
      if ($urandom_range(99) < noise) send_request(OpDrain, 8'($urandom_range(255)));
      send_request(OpPixel, extremes ? ($urandom_range(1) ? 8'hff : 8'h00)
                                     : 8'($urandom_range(255)));
    end
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(99) < noise) send_request(OpPixel, 8'($urandom_range(255)));
      send_request(OpDrain, 8'($urandom_range(255)));
    end
    frame_items += w * h + w;
  endtask

  initial begin
    int unsigned      w;
    int unsigned      h;
    int unsigned      weff;
    int unsigned      heff;
    int unsigned      rows;
    int unsigned      cut;
    int unsigned      hnew;
    int unsigned      r;
    logic [GainW-1:0] g;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgImageWidth;
    cfg_data_i  = '0;
    send_idle   = 0;
    recv_idle   = 0;
    frame_items = 0;
    rst_ni      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // part of a first row at the reset geometry, then a stray drain tick
    for (int i = 0; i < 5; i++) send_request(OpPixel, (i == 0) ? 8'hff : 8'h00);
    send_request(OpDrain, 8'hff);
    wait_idle();
    // width now below the column reached, full gain, checkerboard
    configure(11'd3, 11'd3, 8'hff);
    for (int i = 0; i < 9; i++) send_request(OpPixel, (i % 2 == 1) ? 8'h00 : 8'hff);
    send_request(OpDrain, 8'h00);
    send_request(OpPixel, 8'h5a);
    send_request(OpDrain, 8'hff);
    send_request(OpDrain, 8'h81);
    wait_idle();
    // zero width and height read as one, zero gain
    configure(11'd0, 11'd0, 8'h00);
    send_request(OpPixel, 8'hff);
    send_request(OpDrain, 8'h00);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 33;
          recv_idle = 87;
        end
        1: begin
          send_idle = 87;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      frame_items = 0;
      while (frame_items < 220) begin
        w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
        r = $urandom_range(9);
        g = (r == 0) ? 8'h00 : ((r == 1) ? 8'hff : 8'($urandom_range(255)));
        weff = (w == 0) ? 1 : w;
        heff = (h == 0) ? 1 : h;
        configure(CfgW'(w), CfgW'(h), g);
        if (heff >= 3 && $urandom_range(4) == 0) begin
          // break off two or more rows in, then shrink the height so the frame restarts
          rows = $urandom_range(2, heff - 1);
          cut  = rows * weff + $urandom_range(weff - 1);
          for (int i = 0; i < cut; i++) send_request(OpPixel, 8'($urandom_range(255)));
          frame_items += cut;
          wait_idle();
          hnew = $urandom_range(1, rows - 1);
          configure(CfgW'(w), CfgW'(hnew), g);
          send_frame(weff, hnew, 1'b0, 0, -1);
        end else begin
          send_frame(weff, heff, $urandom_range(3) == 0, (phase == 2) ? 0 : 8 * $urandom_range(1),
                     ($urandom_range(7) == 0) ? $urandom_range(weff * heff - 1) : -1);
        end
        wait_idle();
      end
    end

    // widest row: the width saturates, so the stored row closes after MAX_WIDTH pixels
    configure(11'h7ff, 11'd1, 8'($urandom_range(255)));
    for (int i = 0; i < LefMaxWidth; i++) send_request(OpPixel, 8'($urandom_range(255)));
    wait_idle();
    // a single-column width then ends the drain after one tick
    configure(11'd1, 11'd1, 8'($urandom_range(255)));
    send_request(OpDrain, 8'h00);
    wait_idle();
    // tall single-column frame
    configure(11'd1, 11'd120, 8'($urandom_range(255)));
    send_frame(1, 120, 1'b1, 0, -1);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("[laplacian_edge_filter] OK");
    end else begin
      $display("[laplacian_edge_filter] ERROR");
    end
    $finish;
  end

endmodule
